>>> sv/mrq_pkg.sv
// Shared types and codes for the message ring queue.
// No dependencies; imported by message_ring_queue.
package mrq_pkg;

   localparam logic CMD_ENQ = 1'b0;
   localparam logic CMD_DEQ = 1'b1;

   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_FULL  = 3'd1;
   localparam logic [2:0] ST_EMPTY = 3'd2;
   localparam logic [2:0] ST_SMALL = 3'd3;
   localparam logic [2:0] ST_LONG  = 3'd4;

   typedef enum logic [1:0] {
      REJ_NONE,
      REJ_FULL,
      REJ_LONG
   } rej_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LEN,
      S_STREAM
   } state_type;

   typedef struct packed {
      logic       cmd;
      logic [7:0] data_byte;
      logic       last;
      logic [6:0] capacity;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] out_byte;
      logic       has_byte;
      logic       out_last;
   } rsp_type;

endpackage

>>> sv/message_ring_queue.sv
// Message ring queue: slot ring with used marks, length and byte memories.
// Depends on mrq_pkg for word types, status codes and state encoding.
//
// Usage: the req channel carries one word per enqueue byte (cmd 0, with
// data_byte and last) or one dequeue request (cmd 1, with capacity). The rsp
// channel returns status words. An enqueued message gives one word when its
// last byte arrives: ok, full or too long. A dequeue gives one word with ok
// (zero capacity), empty or too small, or else streams the stored message,
// one byte per word, out_last on the final byte.
// Timing: the result of a final byte is shown the next cycle, as is the
// answer to a zero-capacity or empty dequeue. A stored message is found
// through the registered length memory read (state S_LEN), which decides
// a too-small answer; a stream then passes each byte through the registered
// read port of the byte memory and the output register, one per cycle
// while rsp is not stalled, paced by the single read port of the byte memory.
// Reset: all slots free, both pointers at slot 0, no message in progress.
// Stall: a stalled rsp word holds in the output register; the stream pauses
// behind it and req_stall stays high until the dequeue completes.
module message_ring_queue #(
   parameter int SLOTS     = 8,
   parameter int MAX_BYTES = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  mrq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mrq_pkg::rsp_type rsp_data
);
   import mrq_pkg::*;

   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int IDX_W  = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
   localparam int CNT_W  = $clog2(MAX_BYTES + 1);
   localparam int DEPTH  = SLOTS * (2 ** IDX_W);

   logic [7:0]       byte_mem [DEPTH];
   logic [CNT_W-1:0] len_mem  [SLOTS];

   state_type          state_ff, state_in;
   logic [SLOTS-1:0]   used_ff, used_in;
   logic [SLOT_W-1:0]  write_slot_ff, write_slot_in;
   logic [SLOT_W-1:0]  read_slot_ff, read_slot_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   rej_type            reject_ff, reject_in;
   logic [6:0]         cap_ff, cap_in;
   logic [CNT_W-1:0]   len_ff, len_in;
   logic [CNT_W-1:0]   len_rd_ff;
   logic [CNT_W-1:0]   rd_idx_ff, rd_idx_in;
   logic               dvalid_ff, dvalid_in;
   logic               dlast_ff, dlast_in;
   logic [7:0]         rd_data_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic                    out_ready;
   logic                    req_acc;
   logic                    bw_en;
   logic [SLOT_W+IDX_W-1:0] bw_addr;
   logic                    br_en;
   logic [SLOT_W+IDX_W-1:0] br_addr;
   logic                    len_we;
   logic                    issue;
   logic                    stream_done;
   logic                    deq_hit;

   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] p);
      logic [SLOT_W-1:0] r;
      if (p == SLOT_W'(SLOTS - 1)) r = '0;
      else r = p + SLOT_W'(1);
      return r;
   endfunction

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || !out_ready;
   assign req_acc   = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign deq_hit = req_acc && (req_data.cmd == CMD_DEQ) && (req_data.capacity != 7'd0)
                    && used_ff[read_slot_ff];
   assign issue       = (rd_idx_ff != len_ff) && (!dvalid_ff || out_ready);
   assign stream_done = (rd_idx_ff == len_ff) && (!dvalid_ff || out_ready);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (deq_hit) state_in = S_LEN;
         end
         S_LEN: begin
            if ((len_rd_ff == '0) || ({1'b0, len_rd_ff} > {1'b0, cap_ff})) state_in = S_IDLE;
            else state_in = S_STREAM;
         end
         S_STREAM: begin
            if (stream_done) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      rej_type          rej;
      logic [CNT_W-1:0] cnt;
      logic [2:0]       st;
      used_in       = used_ff;
      write_slot_in = write_slot_ff;
      read_slot_in  = read_slot_ff;
      count_in      = count_ff;
      reject_in     = reject_ff;
      cap_in        = cap_ff;
      len_in        = len_ff;
      rd_idx_in     = rd_idx_ff;
      dvalid_in     = dvalid_ff;
      dlast_in      = dlast_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;
      bw_en         = 1'b0;
      bw_addr       = {write_slot_ff, count_ff[IDX_W-1:0]};
      br_en         = 1'b0;
      br_addr       = {read_slot_ff, rd_idx_ff[IDX_W-1:0]};
      len_we        = 1'b0;
      rej           = reject_ff;
      cnt           = count_ff;
      st            = ST_OK;
      unique case (state_ff)
         S_IDLE: begin
            if (req_acc && (req_data.cmd == CMD_ENQ)) begin
               if ((count_ff == '0) && (reject_ff == REJ_NONE) && used_ff[write_slot_ff])
                  rej = REJ_FULL;
               if (rej == REJ_NONE) begin
                  if (count_ff >= CNT_W'(MAX_BYTES)) begin
                     rej = REJ_LONG;
                  end else begin
                     bw_en = 1'b1;
                     cnt   = count_ff + CNT_W'(1);
                  end
               end
               if (req_data.last) begin
                  case (rej)
                     REJ_FULL: st = ST_FULL;
                     REJ_LONG: st = ST_LONG;
                     default: begin
                        st                     = ST_OK;
                        len_we                 = 1'b1;
                        used_in[write_slot_ff] = 1'b1;
                        write_slot_in          = next_slot(write_slot_ff);
                     end
                  endcase
                  count_in     = '0;
                  reject_in    = REJ_NONE;
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{status: st, out_byte: 8'd0, has_byte: 1'b0, out_last: 1'b1};
               end else begin
                  count_in  = cnt;
                  reject_in = rej;
               end
            end else if (req_acc) begin
               cap_in = req_data.capacity;
               if (req_data.capacity == 7'd0) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = '{status: ST_OK, out_byte: 8'd0, has_byte: 1'b0, out_last: 1'b1};
               end else if (!used_ff[read_slot_ff]) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = '{status: ST_EMPTY, out_byte: 8'd0, has_byte: 1'b0, out_last: 1'b1};
               end
            end
         end
         S_LEN: begin
            len_in    = len_rd_ff;
            rd_idx_in = '0;
            dvalid_in = 1'b0;
            if ({1'b0, len_rd_ff} > {1'b0, cap_ff}) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{status: ST_SMALL, out_byte: 8'd0, has_byte: 1'b0, out_last: 1'b1};
            end else if (len_rd_ff == '0) begin
               rsp_valid_in          = 1'b1;
               rsp_in = '{status: ST_OK, out_byte: 8'd0, has_byte: 1'b0, out_last: 1'b1};
               used_in[read_slot_ff] = 1'b0;
               read_slot_in          = next_slot(read_slot_ff);
            end
         end
         S_STREAM: begin
            if (dvalid_ff && out_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{status: ST_OK, out_byte: rd_data_ff, has_byte: 1'b1,
                          out_last: dlast_ff};
            end
            if (issue) begin
               br_en     = 1'b1;
               dvalid_in = 1'b1;
               dlast_in  = ((rd_idx_ff + CNT_W'(1)) == len_ff);
               rd_idx_in = rd_idx_ff + CNT_W'(1);
            end else if (out_ready) begin
               dvalid_in = 1'b0;
            end
            if (stream_done) begin
               used_in[read_slot_ff] = 1'b0;
               read_slot_in          = next_slot(read_slot_ff);
            end
         end
         default: ;
      endcase
   end

   // byte storage: one write port for enqueue, one registered read port
   always_ff @(posedge clock) begin
      if (bw_en) byte_mem[bw_addr] <= req_data.data_byte;
      if (br_en) rd_data_ff <= byte_mem[br_addr];
   end

   // length storage: written at commit, read at the read slot every cycle
   always_ff @(posedge clock) begin
      if (len_we) len_mem[write_slot_ff] <= count_in == '0 ? (bw_en ? count_ff + CNT_W'(1)
                                                                    : count_ff)
                                                           : count_in;
      len_rd_ff <= len_mem[read_slot_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         used_ff       <= '0;
         write_slot_ff <= '0;
         read_slot_ff  <= '0;
         count_ff      <= '0;
         reject_ff     <= REJ_NONE;
         rd_idx_ff     <= '0;
         dvalid_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         write_slot_ff <= write_slot_in;
         read_slot_ff  <= read_slot_in;
         count_ff      <= count_in;
         reject_ff     <= reject_in;
         rd_idx_ff     <= rd_idx_in;
         dvalid_ff     <= dvalid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cap_ff   <= cap_in;
      len_ff   <= len_in;
      dlast_ff <= dlast_in;
      rsp_ff   <= rsp_in;
   end

   a_dvalid_in_stream: assert property (@(posedge clock) disable iff (reset)
      dvalid_ff |-> (state_ff == S_STREAM))
      else $error("read data stage valid outside a stream");

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_STREAM) |-> (rd_idx_ff <= len_ff))
      else $error("stream read index passed message length");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_BYTES))
      else $error("incoming count above maximum message size");

   a_slot_freed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_STREAM && state_in == S_IDLE) |=> !used_ff[$past(read_slot_ff)])
      else $error("slot still used after its message was streamed");

endmodule
